### sv/cpdec_pkg.sv
// Shared types, constants and helper functions of the CP932 to UTF-8 decoder.
// No dependencies; every other file of the decoder imports this package.
package cpdec_pkg;

   typedef enum logic {
      CMD_DECODE      = 1'b0,
      CMD_TABLE_WRITE = 1'b1
   } cmd_type;

   // Code table geometry.
   localparam logic [7:0] TRAIL_FIRST = 8'h40;
   localparam logic [7:0] TRAIL_LAST  = 8'hfc;
   localparam int         LEAD_ROWS   = 60;
   localparam int         TABLE_COLS  = 189;
   localparam int         TABLE_DEPTH = LEAD_ROWS * TABLE_COLS;
   localparam int         ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int         ROW_W       = 6;

   // Byte classes and code points.
   localparam logic [7:0]  LEAD_LO_FIRST = 8'h81;
   localparam logic [7:0]  LEAD_LO_LAST  = 8'h9f;
   localparam logic [7:0]  LEAD_HI_FIRST = 8'he0;
   localparam logic [7:0]  LEAD_HI_LAST  = 8'hfc;
   localparam logic [7:0]  KANA_FIRST    = 8'ha1;
   localparam logic [7:0]  KANA_LAST     = 8'hdf;
   localparam logic [7:0]  ASCII_LIMIT   = 8'h80;
   localparam logic [15:0] KANA_BASE     = 16'hff61;
   localparam logic [15:0] REPLACEMENT   = 16'hfffd;
   localparam logic [15:0] TWO_BYTE_MIN  = 16'h0080;
   localparam logic [15:0] THREE_BYTE_MIN = 16'h0800;
   localparam logic [7:0]  UTF8_LEAD2    = 8'hc0;
   localparam logic [7:0]  UTF8_LEAD3    = 8'he0;
   localparam logic [7:0]  UTF8_CONT     = 8'h80;
   localparam logic [5:0]  UTF8_CONT_MASK = 6'h3f;

   // Code point queue between the front and back ends.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      cmd_type     command;
      logic [7:0]  data_byte;
      logic        end_of_text;
      logic [5:0]  table_row;
      logic [7:0]  table_column;
      logic [15:0] table_value;
   } req_type;

   typedef struct packed {
      logic [7:0] utf8_byte;
      logic       last_of_run;
      logic       text_done;
   } rsp_type;

   // One or two code points produced by one text byte.
   typedef struct packed {
      logic [15:0] code0;
      logic [15:0] code1;
      logic [1:0]  count;
      logic        eot;
   } code_entry_type;

   function automatic logic is_lead(input logic [7:0] b);
      return (b >= LEAD_LO_FIRST && b <= LEAD_LO_LAST) ||
             (b >= LEAD_HI_FIRST && b <= LEAD_HI_LAST);
   endfunction

   function automatic logic [ROW_W-1:0] row_of_lead_byte(input logic [7:0] b);
      logic [7:0] r;
      if (b <= LEAD_LO_LAST) begin
         r = b - LEAD_LO_FIRST;
      end else begin
         r = b - LEAD_HI_FIRST + (LEAD_LO_LAST - LEAD_LO_FIRST + 8'd1);
      end
      return r[ROW_W-1:0];
   endfunction

   // Code point of a byte decoded on its own; lead bytes are not handled here.
   function automatic logic [15:0] fresh_code(input logic [7:0] b);
      logic [7:0] k;
      k = b - KANA_FIRST;
      if (b < ASCII_LIMIT) begin
         return {8'h00, b};
      end else if (b >= KANA_FIRST && b <= KANA_LAST) begin
         return KANA_BASE + {8'h00, k};
      end else begin
         return REPLACEMENT;
      end
   endfunction

   function automatic logic [1:0] utf8_len(input logic [15:0] code);
      if (code < TWO_BYTE_MIN) begin
         return 2'd1;
      end else if (code < THREE_BYTE_MIN) begin
         return 2'd2;
      end else begin
         return 2'd3;
      end
   endfunction

endpackage

### sv/cpdec_front.sv
// Front end of the CP932 decoder: accepts requests, owns the code table and
// the pending lead byte, and turns each text byte into code points. Uses cpdec_pkg.
module cpdec_front import cpdec_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   output logic           full,
   input  req_type        req_data,
   output logic           q_push,
   output code_entry_type q_entry,
   input  logic           q_full
);

   logic [15:0] table_mem [TABLE_DEPTH];
   logic [15:0] rd_data_ff;

   logic             pending_ff, pending_in;
   logic [ROW_W-1:0] pending_row_ff, pending_row_in;

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_eot_ff;
   logic       s1_pend_ff;
   logic       s1_lookup_ff;
   logic       s1_resolve_ff;

   logic             accept, dec_accept, wr_accept, rd_en;
   logic             trail_ok, in_lead;
   logic [ROW_W-1:0] addr_row;
   logic [7:0]       addr_col;
   logic [ADDR_W-1:0] addr;
   logic [15:0]      s1_code;
   logic             s1_lead, s1_go;
   code_entry_type   entry;

   assign accept     = push && !full;
   assign dec_accept = accept && req_data.command == CMD_DECODE;
   assign wr_accept  = accept && req_data.command == CMD_TABLE_WRITE &&
                       req_data.table_row < ROW_W'(LEAD_ROWS) &&
                       req_data.table_column < 8'(TABLE_COLS);
   assign trail_ok   = req_data.data_byte >= TRAIL_FIRST && req_data.data_byte <= TRAIL_LAST;
   assign in_lead    = is_lead(req_data.data_byte);
   assign rd_en      = dec_accept && pending_ff && trail_ok;

   // One port: a write uses the request's row and column, a read the held row
   // and the trail byte's offset.
   assign addr_row = (req_data.command == CMD_TABLE_WRITE) ? req_data.table_row : pending_row_ff;
   assign addr_col = (req_data.command == CMD_TABLE_WRITE) ? req_data.table_column
                                                           : req_data.data_byte - TRAIL_FIRST;
   assign addr     = ADDR_W'(addr_row) * ADDR_W'(TABLE_COLS) + ADDR_W'(addr_col);

   always_ff @(posedge clock) begin
      if (wr_accept) begin
         table_mem[addr] <= req_data.table_value;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[addr];
      end
   end

   // Second stage: build the code points of the byte held in s1.
   assign s1_code = s1_lookup_ff ? rd_data_ff : 16'h0000;
   assign s1_lead = is_lead(s1_byte_ff);

   always_comb begin
      entry       = '0;
      entry.eot   = s1_eot_ff;
      entry.code0 = REPLACEMENT;
      entry.code1 = REPLACEMENT;
      if (s1_pend_ff && s1_code != 16'h0000) begin
         entry.code0 = s1_code;
         entry.count = 2'd1;
      end else if (s1_pend_ff) begin
         if (s1_lead) begin
            entry.count = s1_eot_ff ? 2'd2 : 2'd1;
         end else begin
            entry.code1 = fresh_code(s1_byte_ff);
            entry.count = 2'd2;
         end
      end else if (s1_lead) begin
         entry.count = s1_eot_ff ? 2'd1 : 2'd0;
      end else begin
         entry.code0 = fresh_code(s1_byte_ff);
         entry.count = 2'd1;
      end
   end

   assign s1_go   = s1_valid_ff && (entry.count == 2'd0 || !q_full);
   assign q_push  = s1_valid_ff && entry.count != 2'd0 && !q_full;
   assign q_entry = entry;
   assign full    = s1_valid_ff && (s1_resolve_ff || !s1_go);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (dec_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   // A lead byte that follows a lead byte stays pending only if the table has
   // no entry for the pair, so that case is settled from the read data.
   always_comb begin
      pending_in     = pending_ff;
      pending_row_in = pending_row_ff;
      if (dec_accept) begin
         pending_in = in_lead && !req_data.end_of_text && !(pending_ff && trail_ok);
         if (in_lead) begin
            pending_row_in = row_of_lead_byte(req_data.data_byte);
         end
      end else if (s1_go && s1_resolve_ff) begin
         pending_in = (s1_code == 16'h0000);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s1_resolve_ff  <= 1'b0;
         pending_ff     <= 1'b0;
         pending_row_ff <= '0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         pending_ff     <= pending_in;
         pending_row_ff <= pending_row_in;
         if (dec_accept) begin
            s1_resolve_ff <= pending_ff && trail_ok && in_lead && !req_data.end_of_text;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dec_accept) begin
         s1_byte_ff   <= req_data.data_byte;
         s1_eot_ff    <= req_data.end_of_text;
         s1_pend_ff   <= pending_ff;
         s1_lookup_ff <= pending_ff && trail_ok;
      end
   end

`ifndef SYNTHESIS
   a_resolve_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_resolve_ff |-> full)
      else $error("request taken while the pending lead byte is unresolved");

   a_pending_row: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> pending_row_ff < ROW_W'(LEAD_ROWS))
      else $error("pending lead byte has a row outside the table");
`endif

endmodule

### sv/cpdec_queue.sv
// Short queue of code point entries between the decoder's front and back ends.
// Uses cpdec_pkg for the entry type and depth.
module cpdec_queue import cpdec_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_en,
   input  code_entry_type wr_entry,
   output logic           full_o,
   input  logic           rd_en,
   output code_entry_type rd_entry,
   output logic           empty_o
);

   code_entry_type entries [QUEUE_DEPTH];

   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   assign full_o   = count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign empty_o  = count_ff == '0;
   assign rd_entry = entries[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries[wr_ptr_ff] <= wr_entry;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && full_o) && !(rd_en && empty_o))
      else $error("code point queue written when full or read when empty");
`endif

endmodule

### sv/cpdec_back.sv
// Back end of the CP932 decoder: expands queued code points into UTF-8 bytes,
// one per cycle into the output register while it is free or being popped. Uses cpdec_pkg.
module cpdec_back import cpdec_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  code_entry_type q_entry,
   input  logic           q_empty,
   output logic           q_pop,
   output logic           empty,
   input  logic           pop,
   output rsp_type        rsp_data
);

   logic       code_idx_ff, code_idx_in;
   logic [1:0] byte_idx_ff, byte_idx_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;

   logic [15:0] code;
   logic [1:0]  code_len;
   logic        last_byte, last_code, step;
   logic [7:0]  utf8;

   assign code      = code_idx_ff ? q_entry.code1 : q_entry.code0;
   assign code_len  = utf8_len(code);
   assign last_byte = byte_idx_ff == code_len - 2'd1;
   assign last_code = {1'b0, code_idx_ff} == q_entry.count - 2'd1;
   assign step      = !q_empty && (!out_valid_ff || pop);
   assign q_pop     = step && last_byte && last_code;

   always_comb begin
      utf8 = code[7:0];
      if (code_len == 2'd2) begin
         utf8 = (byte_idx_ff == 2'd0) ? (UTF8_LEAD2 | {3'b000, code[10:6]})
                                      : (UTF8_CONT | {2'b00, code[5:0] & UTF8_CONT_MASK});
      end else if (code_len == 2'd3) begin
         case (byte_idx_ff)
            2'd0:    utf8 = UTF8_LEAD3 | {4'h0, code[15:12]};
            2'd1:    utf8 = UTF8_CONT | {2'b00, code[11:6]};
            default: utf8 = UTF8_CONT | {2'b00, code[5:0] & UTF8_CONT_MASK};
         endcase
      end
   end

   always_comb begin
      code_idx_in  = code_idx_ff;
      byte_idx_in  = byte_idx_ff;
      out_valid_in = out_valid_ff && !pop;
      if (step) begin
         out_valid_in = 1'b1;
         if (last_byte) begin
            byte_idx_in = 2'd0;
            code_idx_in = !last_code;
         end else begin
            byte_idx_in = byte_idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_idx_ff  <= 1'b0;
         byte_idx_ff  <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         code_idx_ff  <= code_idx_in;
         byte_idx_ff  <= byte_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff.utf8_byte   <= utf8;
         out_ff.last_of_run <= last_byte && last_code;
         out_ff.text_done   <= last_byte && last_code && q_entry.eot;
      end
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

`ifndef SYNTHESIS
   a_byte_idx: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> byte_idx_ff < utf8_len(code))
      else $error("UTF-8 byte index beyond the length of its code point");
`endif

endmodule

### sv/cp932_to_utf8_decoder.sv
// CP932 (Shift-JIS) to UTF-8 decoder top level: front end, code point queue and back
// end, built from cpdec_pkg, cpdec_front, cpdec_queue and cpdec_back.
// The first UTF-8 byte of a request passes the front end's stage register, the queue
// and the output register. One request and one output byte per cycle while nothing stalls;
// a lead byte after a pending lead byte holds off the next request until it is resolved.
// Reset is synchronous and clears all control state; the code table keeps its contents.
module cp932_to_utf8_decoder import cpdec_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   // The front end classifies each request and looks up byte pairs in the
   // code table; each text byte turns into zero, one or two code points.
   logic           q_push, q_full, q_pop, q_empty;
   code_entry_type q_wr_entry, q_rd_entry;

   cpdec_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_entry  (q_wr_entry),
      .q_full   (q_full)
   );

   // The queue lets the front end keep taking requests while the back end is
   // still writing out the bytes of an earlier one.
   cpdec_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_entry (q_wr_entry),
      .full_o   (q_full),
      .rd_en    (q_pop),
      .rd_entry (q_rd_entry),
      .empty_o  (q_empty)
   );

   // The back end expands each code point into one to three UTF-8 bytes and
   // marks the last byte of each request and of the whole text.
   cpdec_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_entry  (q_rd_entry),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

### bench/tb_cp932_to_utf8_decoder.sv
`timescale 1ns / 100ps
// Self-checking testbench of the CP932 to UTF-8 decoder: code table loading, text
// decoding and UTF-8 output checked byte by byte against a predictor kept here.
// Depends on cpdec_pkg and cp932_to_utf8_decoder only.
module tb_cp932_to_utf8_decoder;
   import cpdec_pkg::*;

   // Rows 0..30 belong to the low lead range, the rest to the high lead range.
   localparam int LOW_LEAD_ROWS = int'(LEAD_LO_LAST - LEAD_LO_FIRST) + 1;
   // Cycles without any accepted request or output byte before the run is abandoned.
   localparam int QUIET_LIMIT   = 2000;
   // Number of requests that stop the random stimulus (directed part included).
   localparam int REQUEST_GOAL  = 130;

   // A pending request, with a flag that makes the sender wait for every
   // expected byte to come out before offering it.
   typedef struct packed {
      req_type req;
      logic    drain_first;
   } stim_item;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_data = '0;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_data;

   cp932_to_utf8_decoder u_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Requests waiting to be driven, and the UTF-8 bytes still expected from the block.
   stim_item stimulus [$];
   rsp_type  utf8_expected [$];

   // Predictor state: the code table as written so far and the held lead byte.
   bit [15:0] code_points [TABLE_DEPTH];
   bit        lead_held = 1'b0;
   int        held_row = 0;

   // Shadow state used while building the stimulus. It follows the same request
   // order as the block, so it knows ahead of time which lead byte is held and
   // which table entries exist. That is how a read of an entry that was never
   // written is kept out of the stimulus.
   bit        gen_written [TABLE_DEPTH];
   bit [15:0] gen_value [TABLE_DEPTH];
   bit        gen_lead_held = 1'b0;
   int        gen_held_row = 0;
   bit        drain_next = 1'b0;
   int        request_count = 0;

   logic drive_enable = 1'b0;
   logic req_taken = 1'b0;
   int   requests_taken = 0;
   int   failures = 0;
   int   quiet_cycles = 0;
   logic steady_stretch;

   // Neither side idles at random while this stretch of requests goes through the block.
   assign steady_stretch = (requests_taken >= 70) && (requests_taken < 110);

   function automatic int row_of_byte(input logic [7:0] b);
      if (b >= LEAD_LO_FIRST && b <= LEAD_LO_LAST) begin
         return int'(b) - int'(LEAD_LO_FIRST);
      end
      if (b >= LEAD_HI_FIRST && b <= LEAD_HI_LAST) begin
         return int'(b) - int'(LEAD_HI_FIRST) + LOW_LEAD_ROWS;
      end
      return -1;
   endfunction

   function automatic logic [7:0] lead_byte_of(input int row);
      if (row < LOW_LEAD_ROWS) begin
         return LEAD_LO_FIRST + row[7:0];
      end
      return LEAD_HI_FIRST + row[7:0] - LOW_LEAD_ROWS[7:0];
   endfunction

   function automatic int entry_index(input int row, input int col);
      return row * TABLE_COLS + col;
   endfunction

   function automatic logic is_trail(input logic [7:0] b);
      return b >= TRAIL_FIRST && b <= TRAIL_LAST;
   endfunction

   // A nonzero code point whose UTF-8 form is one, two or three bytes long.
   function automatic logic [15:0] random_code_point();
      case ($urandom_range(2))
         0: begin
            return 16'($urandom_range(127, 1));
         end
         1: begin
            return 16'($urandom_range(2047, 128));
         end
         default: begin
            return 16'($urandom_range(65535, 2048));
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   task automatic put_utf8_byte(input logic [7:0] b);
      rsp_type r;
      r.utf8_byte   = b;
      r.last_of_run = 1'b0;
      r.text_done   = 1'b0;
      utf8_expected.push_back(r);
   endtask

   task automatic put_code_point(input logic [15:0] cp);
      if (cp < TWO_BYTE_MIN) begin
         put_utf8_byte(cp[7:0]);
      end else if (cp < THREE_BYTE_MIN) begin
         put_utf8_byte(UTF8_LEAD2 | {3'b000, cp[10:6]});
         put_utf8_byte(UTF8_CONT | {2'b00, cp[5:0]});
      end else begin
         put_utf8_byte(UTF8_LEAD3 | {4'b0000, cp[15:12]});
         put_utf8_byte(UTF8_CONT | {2'b00, cp[11:6]});
         put_utf8_byte(UTF8_CONT | {2'b00, cp[5:0]});
      end
   endtask

   // A byte taken on its own: ASCII, halfwidth katakana, a lead byte that is
   // now held, or a stray high byte that becomes the replacement character.
   task automatic decode_single(input logic [7:0] b);
      int row;
      row = row_of_byte(b);
      if (b < ASCII_LIMIT) begin
         put_utf8_byte(b);
      end else if (b >= KANA_FIRST && b <= KANA_LAST) begin
         put_code_point(KANA_BASE + {8'h00, b - KANA_FIRST});
      end else if (row >= 0) begin
         lead_held = 1'b1;
         held_row  = row;
      end else begin
         put_code_point(REPLACEMENT);
      end
   endtask

   // Works out the UTF-8 bytes that one accepted request gives, and appends them
   // to the expected bytes with the run and text markers on the last one.
   task automatic decode_request(input req_type q);
      int          first;
      logic [15:0] cp;
      rsp_type     tail;
      first = utf8_expected.size();
      if (q.command == CMD_TABLE_WRITE) begin
         // Writes outside the table are dropped; a held lead byte stays held.
         if (q.table_row < LEAD_ROWS && q.table_column < TABLE_COLS) begin
            code_points[entry_index(q.table_row, q.table_column)] = q.table_value;
         end
      end else begin
         if (lead_held) begin
            lead_held = 1'b0;
            cp = 16'h0000;
            if (is_trail(q.data_byte)) begin
               cp = code_points[entry_index(held_row,
                                            int'(q.data_byte) - int'(TRAIL_FIRST))];
            end
            if (cp != 16'h0000) begin
               put_code_point(cp);
            end else begin
               // A bad or unmapped pair: the replacement character, then the
               // trail byte starts over as a byte of its own.
               put_code_point(REPLACEMENT);
               decode_single(q.data_byte);
            end
         end else begin
            decode_single(q.data_byte);
         end
         // A lead byte still held when the text ends cannot be completed.
         if (q.end_of_text && lead_held) begin
            lead_held = 1'b0;
            put_code_point(REPLACEMENT);
         end
         if (utf8_expected.size() > first) begin
            tail = utf8_expected.pop_back();
            tail.last_of_run = 1'b1;
            tail.text_done   = q.end_of_text;
            utf8_expected.push_back(tail);
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus building
   // ---------------------------------------------------------------------------

   task automatic push_item(input req_type r);
      stim_item item;
      item.req         = r;
      item.drain_first = drain_next;
      drain_next       = 1'b0;
      stimulus.push_back(item);
   endtask

   task automatic queue_write(input int row, input int col, input logic [15:0] value);
      req_type r;
      r.command      = CMD_TABLE_WRITE;
      r.data_byte    = 8'($urandom_range(255));
      r.end_of_text  = 1'($urandom_range(1));
      r.table_row    = row[5:0];
      r.table_column = col[7:0];
      r.table_value  = value;
      push_item(r);
      request_count++;
      // A write outside the table leaves the shadow table as it is.
      if (row < LEAD_ROWS && col < TABLE_COLS) begin
         gen_written[entry_index(row, col)] = 1'b1;
         gen_value[entry_index(row, col)]   = value;
      end
   endtask

   // Queues one text byte. If it would complete a pair whose table entry was
   // never written, that entry is written first with a random code point.
   task automatic queue_text(input logic [7:0] b, input logic eot);
      req_type r;
      int      col;
      int      row;
      logic    fresh;
      col = int'(b) - int'(TRAIL_FIRST);
      if (gen_lead_held && is_trail(b) && !gen_written[entry_index(gen_held_row, col)]) begin
         queue_write(gen_held_row, col, random_code_point());
      end
      r.command      = CMD_DECODE;
      r.data_byte    = b;
      r.end_of_text  = eot;
      r.table_row    = 6'($urandom_range(63));
      r.table_column = 8'($urandom_range(255));
      r.table_value  = 16'($urandom_range(65535));
      push_item(r);
      request_count++;

      // Follow the held lead byte the way the block will.
      fresh = 1'b1;
      if (gen_lead_held) begin
         gen_lead_held = 1'b0;
         if (is_trail(b) && gen_value[entry_index(gen_held_row, col)] != 16'h0000) begin
            fresh = 1'b0;
         end
      end
      row = row_of_byte(b);
      if (fresh && row >= 0) begin
         gen_lead_held = 1'b1;
         gen_held_row  = row;
      end
      if (eot) begin
         gen_lead_held = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Driver: offers requests and takes output bytes, both with random idling.
   // Inputs change on the falling edge only.
   // ---------------------------------------------------------------------------

   always @(negedge clock) begin
      if (!drive_enable) begin
         push <= 1'b0;
         pop  <= 1'b0;
      end else begin
         pop <= steady_stretch || ($urandom_range(99) >= 23);
         // A request that is offered stays offered until the block takes it.
         if (!push || req_taken) begin
            if (stimulus.size() == 0) begin
               push <= 1'b0;
            end else if (stimulus[0].drain_first && utf8_expected.size() != 0) begin
               // Hold back until the block has given out everything it owes.
               push <= 1'b0;
            end else if (!steady_stretch && $urandom_range(99) < 23) begin
               push <= 1'b0;
            end else begin
               push     <= 1'b1;
               req_data <= stimulus[0].req;
            end
         end
      end
   end

   // Request capture: every request the block accepts goes through the predictor.
   always @(posedge clock) begin
      req_taken <= !reset && push && !full;
      if (!reset && push && !full) begin
         decode_request(req_data);
         stimulus.delete(0);
         requests_taken <= requests_taken + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: each output byte taken is checked against the oldest expected one.
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (utf8_expected.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("unexpected output byte %02h last_of_run %0b text_done %0b",
                        rsp_data.utf8_byte, rsp_data.last_of_run, rsp_data.text_done);
            end
         end else begin
            want = utf8_expected.pop_front();
            if (rsp_data.utf8_byte !== want.utf8_byte ||
                rsp_data.last_of_run !== want.last_of_run ||
                rsp_data.text_done !== want.text_done) begin
               failures++;
               if (failures <= 10) begin
                  $display("output byte mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                           want.utf8_byte, want.last_of_run, want.text_done,
                           rsp_data.utf8_byte, rsp_data.last_of_run, rsp_data.text_done);
               end
            end
         end
      end
   end

   // Watchdog: the run is abandoned when nothing moves for too long.
   always @(posedge clock) begin
      if (drive_enable) begin
         if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ---------------------------------------------------------------------------

   initial begin
      int          round;
      int          kind;
      int          row;
      int          col;
      logic [7:0]  b;

      // Directed part. The table entries come first: a three-byte code at the
      // first entry, the largest code point at the last entry, a two-byte code
      // at the first row of the high lead range, two entries mapped to zero and
      // one write outside the table that must be dropped.
      queue_write(0, 0, 16'h3042);
      queue_write(LEAD_ROWS - 1, TABLE_COLS - 1, 16'hffff);
      queue_write(LOW_LEAD_ROWS, 0, 16'h00a9);
      queue_write(1, 1, 16'h0000);
      queue_write(1, int'(8'h82) - int'(TRAIL_FIRST), 16'h0000);
      queue_write(63, 255, 16'h1234);
      // ASCII and katakana extremes, then stray high bytes.
      queue_text(8'h00, 1'b0);
      queue_text(8'h7f, 1'b0);
      queue_text(KANA_FIRST, 1'b0);
      queue_text(KANA_LAST, 1'b0);
      queue_text(8'h80, 1'b0);
      queue_text(8'hff, 1'b1);
      // Pairs at both ends of the table, one ending the text.
      queue_text(LEAD_LO_FIRST, 1'b0);
      queue_text(TRAIL_FIRST, 1'b0);
      queue_text(LEAD_HI_LAST, 1'b0);
      queue_text(TRAIL_LAST, 1'b1);
      queue_text(LEAD_HI_FIRST, 1'b0);
      queue_text(TRAIL_FIRST, 1'b0);
      // A zero-mapped pair whose trail byte comes out as plain ASCII.
      queue_text(8'h82, 1'b0);
      queue_text(8'h41, 1'b0);
      // A trail byte below the trail range.
      queue_text(LEAD_LO_FIRST, 1'b0);
      queue_text(8'h3f, 1'b0);
      // A zero-mapped pair whose trail byte is a lead byte again, at the end of
      // the text: two replacement characters from one request.
      queue_text(8'h82, 1'b0);
      queue_text(8'h82, 1'b1);

      // Random part. The sender first waits for the directed bytes to drain.
      drain_next = 1'b1;
      round = 0;
      while (request_count < REQUEST_GOAL) begin
         round++;
         if (round == 40) begin
            drain_next = 1'b1;
         end
         kind = $urandom_range(99);
         row  = $urandom_range(LEAD_ROWS - 1);
         col  = $urandom_range(TABLE_COLS - 1);
         if (kind < 45) begin
            // Well-formed double-byte character, loading its entry when needed.
            if (!gen_written[entry_index(row, col)] ||
                gen_value[entry_index(row, col)] == 16'h0000 ||
                $urandom_range(9) == 0) begin
               queue_write(row, col, random_code_point());
            end
            queue_text(lead_byte_of(row), 1'b0);
            queue_text(TRAIL_FIRST + col[7:0], $urandom_range(9) == 0);
         end else if (kind < 60) begin
            // Single-byte character: ASCII or halfwidth katakana.
            if ($urandom_range(1) == 0) begin
               b = 8'($urandom_range(127));
            end else begin
               b = 8'($urandom_range(KANA_LAST, KANA_FIRST));
            end
            queue_text(b, $urandom_range(9) == 0);
         end else if (kind < 68) begin
            // Broken pair: the trail byte falls outside the trail range.
            queue_text(lead_byte_of(row), 1'b0);
            if ($urandom_range(1) == 0) begin
               b = 8'($urandom_range(int'(TRAIL_FIRST) - 1));
            end else begin
               b = 8'($urandom_range(255, int'(TRAIL_LAST) + 1));
            end
            queue_text(b, $urandom_range(9) == 0);
         end else if (kind < 74) begin
            // Pair that reaches an entry mapped to zero.
            queue_write(row, col, 16'h0000);
            queue_text(lead_byte_of(row), 1'b0);
            queue_text(TRAIL_FIRST + col[7:0], $urandom_range(9) == 0);
         end else if (kind < 84) begin
            // Noise: any byte at all.
            queue_text(8'($urandom_range(255)), $urandom_range(4) == 0);
         end else if (kind < 90) begin
            // Text that ends on a lead byte.
            queue_text(lead_byte_of(row), 1'b1);
         end else if (kind < 95) begin
            // Table write outside the table.
            if ($urandom_range(1) == 0) begin
               queue_write($urandom_range(63, LEAD_ROWS), $urandom_range(255),
                           16'($urandom_range(65535)));
            end else begin
               queue_write($urandom_range(63), $urandom_range(255, TABLE_COLS),
                           16'($urandom_range(65535)));
            end
         end else begin
            // Overwrite of an entry with any value, zero included.
            queue_write(row, col, 16'($urandom_range(65535)));
         end
      end

      // Hold reset first, then release it and start the driver on a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset        <= 1'b0;
      drive_enable <= 1'b1;

      // Wait until every request has been taken and every byte has come out,
      // then give the block time to show any byte it should not produce.
      while (stimulus.size() != 0 || utf8_expected.size() != 0) begin
         @(negedge clock);
      end
      repeat (20) @(negedge clock);

      if (failures == 0 && utf8_expected.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
sv/cpdec_pkg.sv
sv/cpdec_front.sv
sv/cpdec_queue.sv
sv/cpdec_back.sv
sv/cp932_to_utf8_decoder.sv
bench/tb_cp932_to_utf8_decoder.sv
